FILE: design/iatc_pkg.sv
// Shared types, constants and helpers for the IPv6 address text compressor.
package iatc_pkg;

    localparam int GROUP_BITS  = 16;
    localparam int GROUP_COUNT = 8;
    localparam int GIDX_W      = $clog2(GROUP_COUNT);
    localparam int NIB_COUNT   = GROUP_BITS / 4;
    localparam int CHAR_W      = 7;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3A;

    // Per-group lane result: digit count and digits, most significant first.
    typedef struct packed {
        logic [2:0]                          dig_cnt;
        logic [NIB_COUNT-1:0][CHAR_W-1:0]    digs;
    } lane_t;

    // Zero run picked by the merge stage.
    typedef struct packed {
        logic              has_run;
        logic [GIDX_W-1:0] run_start;
        logic [GIDX_W-1:0] run_end;
    } run_t;

    // Everything the serializer needs for one address.
    typedef struct packed {
        run_t                         run;
        logic [GROUP_COUNT-1:0] [$bits(lane_t)-1:0] lanes;
    } plan_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10)
        begin
            c = 7'h30 + {3'b000, nib};
        end
        else
        begin
            c = 7'h57 + {3'b000, nib};
        end
        return c;
    endfunction

endpackage

FILE: design/iatc_lane.sv
// One group lane: zero detect, digit count and lowercase hex digits.
module iatc_lane (
    input  logic [iatc_pkg::GROUP_BITS-1:0] group_val,
    output logic                            is_zero,
    output iatc_pkg::lane_t                 lane
);
    import iatc_pkg::*;

    logic [NIB_COUNT-1:0][3:0] nib;
    logic [1:0]                top_idx;

    assign nib     = group_val;
    assign is_zero = (group_val == '0);

    always_comb
    begin
        if (nib[3] != 4'd0)
        begin
            lane.dig_cnt = 3'd4;
        end
        else if (nib[2] != 4'd0)
        begin
            lane.dig_cnt = 3'd3;
        end
        else if (nib[1] != 4'd0)
        begin
            lane.dig_cnt = 3'd2;
        end
        else
        begin
            lane.dig_cnt = 3'd1;
        end
        top_idx = 2'(lane.dig_cnt - 3'd1);
        // Digit j is nibble (count-1-j); positions past the count are never read.
        for (int j = 0; j < NIB_COUNT; j++)
        begin
            lane.digs[j] = hex_char(nib[2'(top_idx - 2'(j))]);
        end
    end

endmodule

FILE: design/iatc_merge.sv
// Merge stage: pick the longest zero run across lanes, rightmost on a tie.
module iatc_merge (
    input  logic [iatc_pkg::GROUP_COUNT-1:0] zero,
    output iatc_pkg::run_t                   run
);
    import iatc_pkg::*;

    logic [GROUP_COUNT-1:0][GIDX_W:0] len_end;
    logic [GIDX_W:0]                  best_len;
    logic [GIDX_W-1:0]                best_end;

    always_comb
    begin
        // Length of the zero run ending at each group.
        len_end[0] = zero[0] ? (GIDX_W+1)'(1) : '0;
        for (int k = 1; k < GROUP_COUNT; k++)
        begin
            if (!zero[k])
            begin
                len_end[k] = '0;
            end
            else
            begin
                len_end[k] = len_end[k-1] + (GIDX_W+1)'(1);
            end
        end
        best_len = '0;
        best_end = '0;
        for (int k = 0; k < GROUP_COUNT; k++)
        begin
            if (len_end[k] != '0 && len_end[k] >= best_len)
            begin
                best_len = len_end[k];
                best_end = GIDX_W'(k);
            end
        end
        run.has_run   = (best_len != '0);
        run.run_end   = best_end;
        run.run_start = GIDX_W'(best_end - GIDX_W'(best_len - (GIDX_W+1)'(1)));
    end

endmodule

FILE: design/iatc_serializer.sv
// Character serializer: walk the plan one group at a time, one char per beat.
module iatc_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            plan_valid,
    input  iatc_pkg::plan_t plan_in,
    output logic            plan_take,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);
    import iatc_pkg::*;

    plan_t             plan_reg;
    logic              busy_reg;
    logic [GIDX_W-1:0] grp_reg;
    logic [2:0]        pos_reg;
    logic              m_tvalid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    lane_t             cur;
    logic              is_start;
    logic              add_colon;
    logic [2:0]        glen;
    logic [GIDX_W:0]   next_grp;
    logic [CHAR_W-1:0] ch;
    logic              grp_end;
    logic              last_char;
    logic              adv;

    always_comb
    begin
        cur       = lane_t'(plan_reg.lanes[grp_reg]);
        is_start  = plan_reg.run.has_run && (grp_reg == plan_reg.run.run_start);
        add_colon = (grp_reg != GIDX_W'(GROUP_COUNT - 1)) &&
                    !(plan_reg.run.has_run &&
                      ({1'b0, grp_reg} + (GIDX_W+1)'(1)) == {1'b0, plan_reg.run.run_start});
        if (is_start)
        begin
            // The run prints as two colons, then skip past it.
            ch       = CHAR_COLON;
            glen     = 3'd2;
            next_grp = {1'b0, plan_reg.run.run_end} + (GIDX_W+1)'(1);
        end
        else
        begin
            ch       = (pos_reg < cur.dig_cnt) ? cur.digs[pos_reg[1:0]] : CHAR_COLON;
            glen     = cur.dig_cnt + {2'b00, add_colon};
            next_grp = {1'b0, grp_reg} + (GIDX_W+1)'(1);
        end
        grp_end   = (pos_reg == glen - 3'd1);
        last_char = grp_end && next_grp[GIDX_W];
        adv       = busy_reg && (!m_tvalid_reg || m_tready);
        plan_take = plan_valid && (!busy_reg || (adv && last_char));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            grp_reg      <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            if (adv)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (plan_take)
            begin
                busy_reg <= 1'b1;
                grp_reg  <= '0;
                pos_reg  <= '0;
            end
            else if (adv)
            begin
                if (grp_end)
                begin
                    grp_reg <= next_grp[GIDX_W-1:0];
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + 3'd1;
                end
                if (last_char)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            char_reg <= ch;
            last_reg <= last_char;
        end
        if (plan_take)
        begin
            plan_reg <= plan_in;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

endmodule

FILE: design/ipv6_address_text_compressor_top.sv
// Top level of the IPv6 address text compressor: lanes, merge, holding slot, serializer.
//
//   Channel   Direction  Payload (lowest bit first)                Marker
//   s_axis    in         tdata[63:0] addr_high, [127:64] addr_low  -
//   m_axis    out        tdata[6:0] text_char, [7] zero            tlast = is_last
//
// Each address leaves as 2 to 39 output beats, one per cycle unless m_tready stalls;
// the serializer's one character per cycle sets the rate. The next address follows
// its predecessor with no gap.
// An address is analyzed in the cycle it is accepted and held in a one-entry
// slot, so one address waits while the previous one is being sent.
// rst_n clears all handshake state asynchronously. A stalled m_tready holds the
// current beat; s_tready drops while the holding slot is full and not being drained.
module ipv6_address_text_compressor_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // addr_high [63:0], addr_low [127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // text_char [6:0], zero pad [7]
    output logic         m_tlast    // is_last
);
    import iatc_pkg::*;

    logic [GROUP_COUNT-1:0]                 zero;
    lane_t                                  lane_out [GROUP_COUNT];
    run_t                                   run;
    plan_t                                  plan_new;
    plan_t                                  pend_reg;
    logic                                   pend_valid_reg;
    logic                                   plan_take;
    logic                                   s_accept;

    // One lane per 16-bit group; group one sits in the top bits of addr_high.
    for (genvar k = 0; k < GROUP_COUNT; k++)
    begin : g_lane
        localparam int HALF_GROUPS = GROUP_COUNT / 2;
        localparam int HALF_BASE   = (k < HALF_GROUPS) ? 0 : 64;
        localparam int TOP_BIT     = HALF_BASE + 63 - GROUP_BITS * (k % HALF_GROUPS);

        iatc_lane u_lane (
            .group_val (s_tdata[TOP_BIT -: GROUP_BITS]),
            .is_zero   (zero[k]),
            .lane      (lane_out[k])
        );

        assign plan_new.lanes[k] = lane_out[k];
    end

    // Combine the lanes' zero flags into the run to compress.
    iatc_merge u_merge (
        .zero (zero),
        .run  (run)
    );

    assign plan_new.run = run;

    // Accept while the slot is empty or being drained this cycle.
    assign s_tready = !pend_valid_reg || plan_take;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (plan_take)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            pend_reg <= plan_new;
        end
    end

    // Emit the held address one character per beat.
    iatc_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (pend_valid_reg),
        .plan_in    (pend_reg),
        .plan_take  (plan_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: tb/ipv6_address_text_compressor_top_test.sv
// Self-checking bench for the IPv6 address text compressor: streams addresses, checks each text beat.
module ipv6_address_text_compressor_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import iatc_pkg::*;

    // One expected text character and its end-of-text flag.
    typedef struct {
        logic [CHAR_W-1:0] text_char;
        logic              is_last;
    } text_beat_t;

    // One address waiting to be sent, with its pacing controls.
    typedef struct {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        int unsigned gap;          // idle cycles before this beat is offered
        bit          drain_first;  // hold until every pending character is out
        bit          calm;         // receiver keeps tready high while set
    } addr_item_t;

    localparam string HEX_DIGITS   = "0123456789abcdef";
    localparam int    RANDOM_ITEMS = 296;
    localparam int    SETTLE_CYCLES = 60;
    localparam int    CALM_FIRST   = 100;
    localparam int    CALM_LAST    = 150;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // addr_high [63:0], addr_low [127:64]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;        // text_char [6:0], zero pad [7]
    logic         m_tlast;        // is_last

    addr_item_t   addr_pending[$];
    text_beat_t   text_due[$];
    addr_item_t   next_addr;
    text_beat_t   due_beat;
    bit           calm_now = 1'b0;
    int unsigned  stall_left = 0;
    int unsigned  fail_count = 0;

    ipv6_address_text_compressor_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Append one character to the expected text.
    function automatic void push_char(input logic [CHAR_W-1:0] c);
        text_beat_t b;
        b.text_char = c;
        b.is_last   = 1'b0;
        text_due.push_back(b);
    endfunction

    // Append one group in lowercase hex, leading zeros dropped, at least one digit.
    function automatic void push_group(input logic [GROUP_BITS-1:0] grp);
        bit          started;
        logic [3:0]  nib;
        byte         hex_ch;
        started = 1'b0;
        for (int d = 3; d >= 0; d--)
        begin
            nib = grp[d*4 +: 4];
            if (nib != 4'd0 || started || d == 0)
            begin
                started = 1'b1;
                hex_ch  = HEX_DIGITS[nib];
                push_char(hex_ch[CHAR_W-1:0]);
            end
        end
    endfunction

    // Work out the full compressed text of one address and queue its characters.
    function automatic void predict_text(input logic [63:0] addr_high,
                                         input logic [63:0] addr_low);
        logic [GROUP_BITS-1:0] grp [GROUP_COUNT];
        logic [127:0]          full;
        int                    best_len;
        int                    run_start;
        int                    run_end;
        int                    j;
        full      = {addr_high, addr_low};
        best_len  = 0;
        run_start = 0;
        run_end   = -1;
        for (int k = 0; k < GROUP_COUNT; k++)
            grp[k] = full[127 - GROUP_BITS*k -: GROUP_BITS];

        // Scan from the right so that only a strictly longer run displaces
        // the one held; ties therefore go to the rightmost run.
        for (int i = GROUP_COUNT - 1; i >= 0; i--)
        begin
            if (grp[i] == '0)
            begin
                j = i;
                while (j >= 0 && grp[j] == '0)
                    j--;
                if (i - j > best_len)
                begin
                    best_len  = i - j;
                    run_start = j + 1;
                    run_end   = i;
                end
            end
        end

        if (best_len == 0)
        begin
            for (int k = 0; k < GROUP_COUNT; k++)
            begin
                push_group(grp[k]);
                if (k < GROUP_COUNT - 1)
                    push_char(CHAR_COLON);
            end
        end
        else
        begin
            for (int k = 0; k < run_start; k++)
            begin
                push_group(grp[k]);
                if (k < run_start - 1)
                    push_char(CHAR_COLON);
            end
            push_char(CHAR_COLON);
            push_char(CHAR_COLON);
            for (int k = run_end + 1; k < GROUP_COUNT; k++)
            begin
                push_group(grp[k]);
                if (k < GROUP_COUNT - 1)
                    push_char(CHAR_COLON);
            end
        end
        text_due[$].is_last = 1'b1;
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Queue one address given as its eight groups, group one in the top bits.
    function automatic void queue_addr(input logic [127:0] groups, input int unsigned gap,
                                       input bit drain_first, input bit calm);
        addr_item_t it;
        it.addr_high   = groups[127:64];
        it.addr_low    = groups[63:0];
        it.gap         = gap;
        it.drain_first = drain_first;
        it.calm        = calm;
        addr_pending.push_back(it);
    endfunction

    // Random address biased toward zero groups and short groups so that runs,
    // ties and leading-zero trimming show up often.
    function automatic logic [127:0] random_addr();
        logic [127:0]          v;
        logic [GROUP_BITS-1:0] grp;
        int unsigned           r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return {$urandom, $urandom, $urandom, $urandom};
        for (int k = 0; k < GROUP_COUNT; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                grp = '0;
            else if (r < 6)
                grp = 16'($urandom_range(1, 16'h0fff) >> (4 * $urandom_range(0, 2)));
            else
                grp = 16'($urandom_range(0, 16'hffff));
            v[127 - GROUP_BITS*k -: GROUP_BITS] = grp;
        end
        return v;
    endfunction

    // Sender: predict on every accepted beat, then offer the next address
    // once the current one is gone. Hold the beat steady while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            calm_now <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_text(s_tdata[63:0], s_tdata[127:64]);
            if (!s_tvalid || s_tready)
            begin
                if (addr_pending.size() == 0)
                    s_tvalid <= 1'b0;
                else if (addr_pending[0].drain_first && text_due.size() != 0)
                    s_tvalid <= 1'b0;
                else if (addr_pending[0].gap != 0)
                begin
                    addr_pending[0].gap = addr_pending[0].gap - 1;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    next_addr = addr_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_addr.addr_low, next_addr.addr_high};
                    calm_now <= next_addr.calm;
                end
            end
        end
    end

    // Receiver: check every accepted text beat against the oldest expected
    // character, then decide whether to stall the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (text_due.size() == 0)
                begin
                    $error("unexpected text beat: text_char 0x%02h is_last %0b",
                           m_tdata[CHAR_W-1:0], m_tlast);
                    fail_count++;
                end
                else
                begin
                    due_beat = text_due.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== due_beat.text_char)
                    begin
                        $error("text_char mismatch: expected 0x%02h, got 0x%02h",
                               due_beat.text_char, m_tdata[CHAR_W-1:0]);
                        fail_count++;
                    end
                    if (m_tlast !== due_beat.is_last)
                    begin
                        $error("is_last mismatch: expected %0b, got %0b",
                               due_beat.is_last, m_tlast);
                        fail_count++;
                    end
                end
            end

            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm_now && $urandom_range(0, 99) < 15)
            begin
                // Start a stall: this cycle counts as its first.
                if ($urandom_range(0, 99) < 85)
                    stall_left = $urandom_range(0, 2);
                else
                    stall_left = $urandom_range(9, 39);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        // Directed: special cases and field extremes.
        queue_addr(128'h0000_0000_0000_0000_0000_0000_0000_0000, 0, 1'b0, 1'b0); // all zero
        queue_addr(128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff, 0, 1'b0, 1'b0); // no zero, longest
        queue_addr(128'h0000_0000_0000_0000_0000_0000_0000_0001, 0, 1'b0, 1'b0); // run at start
        queue_addr(128'h0001_0000_0000_0000_0000_0000_0000_0000, 0, 1'b0, 1'b0); // run at end
        queue_addr(128'h0001_0002_0003_0000_0005_0006_0007_0008, 0, 1'b0, 1'b0); // lone zero
        queue_addr(128'h0001_0000_0000_0002_0003_0000_0000_0004, 0, 1'b0, 1'b0); // tie
        queue_addr(128'h0000_0001_0000_0001_0000_0001_0000_0001, 0, 1'b0, 1'b0); // tie, singles
        queue_addr(128'h0000_0001_0002_0003_0004_0005_0006_0000, 0, 1'b0, 1'b0); // tie at edges
        queue_addr(128'h0000_0000_0001_0000_0000_0000_0001_0000, 0, 1'b0, 1'b0); // longer in middle
        queue_addr(128'h0000_0000_0000_0001_0000_0000_0000_0000, 0, 1'b0, 1'b0); // 3 vs 4 at end
        queue_addr(128'h0001_0010_0100_1000_000f_00f0_0f00_f000, 0, 1'b0, 1'b0); // leading zeros
        queue_addr(128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210, 0, 1'b0, 1'b0); // every digit
        queue_addr(128'haaaa_aaaa_aaaa_aaaa_5555_5555_5555_5555, 0, 1'b0, 1'b0);
        queue_addr(128'h5555_5555_5555_5555_aaaa_aaaa_aaaa_aaaa, 0, 1'b0, 1'b0);
        queue_addr(128'h0000_ffff_ffff_ffff_ffff_ffff_ffff_ffff, 0, 1'b0, 1'b0); // only first zero
        queue_addr(128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_0000, 0, 1'b0, 1'b0); // only last zero
        queue_addr(128'h0000_0000_0000_0000_0000_0000_0000_0000, 0, 1'b1, 1'b0); // after drain
        queue_addr(128'h8000_0001_0000_0000_0000_0000_0000_0000, 0, 1'b0, 1'b0);
        queue_addr(128'h0000_0000_0000_0000_0000_0000_0001_8000, 0, 1'b0, 1'b0);

        // Random: a calm stretch with no idling in the middle, and a few
        // points where the sender waits for the text to drain completely.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= CALM_FIRST && n < CALM_LAST)
                queue_addr(random_addr(), 0, 1'b0, 1'b1);
            else
                queue_addr(random_addr(), pick_gap(), (n % 90) == 45, 1'b0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every address is accepted and every character has come.
        do
            @(posedge clk);
        while (addr_pending.size() != 0 || s_tvalid || text_due.size() != 0);

        // Let any stray trailing beat show up.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (text_due.size() != 0)
        begin
            $error("%0d text characters never arrived", text_due.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
